// ===== sv/sdtc_pkg.sv =====
// ----------------------------------------------------------------------------
// Sobel double-threshold classifier package
// Shared widths, reset values, register indexes, class codes and stage types.
// ----------------------------------------------------------------------------
`default_nettype none

package sdtc_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MIN_DIM        = 3;

    localparam int PIX_W   = 8;
    localparam int DIM_W   = 11;
    localparam int THR_W   = 21;
    localparam int POS_W   = 10;
    localparam int GRAD_W  = 11;
    localparam int SQ_W    = 20;
    localparam int MAG_W   = 21;
    localparam int CLS_W   = 2;
    localparam int IDX_W   = 3;
    localparam int LINE_W  = 2 * PIX_W;

    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH   = 11'd640;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT  = 11'd480;
    localparam logic             RST_DOUBLE_MODE   = 1'b1;
    localparam logic [THR_W-1:0] RST_SINGLE_THRESH = 21'd20800;
    localparam logic [THR_W-1:0] RST_LOW_THRESH    = 21'd9000;
    localparam logic [THR_W-1:0] RST_HIGH_THRESH   = 21'd17800;

    typedef enum logic [IDX_W-1:0] {
        CFG_FRAME_WIDTH   = 3'd0,
        CFG_FRAME_HEIGHT  = 3'd1,
        CFG_DOUBLE_MODE   = 3'd2,
        CFG_SINGLE_THRESH = 3'd3,
        CFG_LOW_THRESH    = 3'd4,
        CFG_HIGH_THRESH   = 3'd5
    } t_cfg_idx;

    typedef enum logic [CLS_W-1:0] {
        CLS_NONE   = 2'd0,
        CLS_WEAK   = 2'd1,
        CLS_STRONG = 2'd2
    } t_cls_code;

    typedef struct packed {
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
        logic             double_mode;
        logic [THR_W-1:0] single_thresh;
        logic [THR_W-1:0] low_thresh;
        logic [THR_W-1:0] high_thresh;
    } t_cfg;

    typedef struct packed {
        logic                     has_int;
        logic                     has_bdr;
        logic [POS_W-1:0]         int_row;
        logic [POS_W-1:0]         int_col;
        logic [POS_W-1:0]         bdr_row;
        logic [POS_W-1:0]         bdr_col;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
    } t_grad;

    typedef struct packed {
        logic             has_int;
        logic             has_bdr;
        logic [POS_W-1:0] int_row;
        logic [POS_W-1:0] int_col;
        t_cls_code        int_cls;
        logic [POS_W-1:0] bdr_row;
        logic [POS_W-1:0] bdr_col;
    } t_cls;

endpackage

`default_nettype wire

// ===== sv/sdtc_if.sv =====
// ----------------------------------------------------------------------------
// Sobel double-threshold classifier channels
// Pixel, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdtc_pix_if;
    logic                        valid;
    logic                        ready;
    logic [sdtc_pkg::PIX_W-1:0]  intensity;

    modport source (output valid, output intensity, input ready);
    modport sink   (input valid, input intensity, output ready);
endinterface

interface sdtc_res_if;
    logic                        valid;
    logic                        ready;
    logic [sdtc_pkg::POS_W-1:0]  pixel_row;
    logic [sdtc_pkg::POS_W-1:0]  pixel_col;
    logic [sdtc_pkg::CLS_W-1:0]  edge_class;
    logic                        last;

    modport source (output valid, output pixel_row, output pixel_col,
                    output edge_class, output last, input ready);
    modport sink   (input valid, input pixel_row, input pixel_col,
                    input edge_class, input last, output ready);
endinterface

interface sdtc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [sdtc_pkg::IDX_W-1:0]  index;
    logic [sdtc_pkg::THR_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/sdtc_cfg.sv =====
// ----------------------------------------------------------------------------
// Sobel classifier register file
// Holds frame size, mode and thresholds; takes one write request per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sdtc_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [sdtc_pkg::IDX_W-1:0] i_index,
    input  wire logic [sdtc_pkg::THR_W-1:0] i_data,
    output sdtc_pkg::t_cfg                  o_cfg
);

    sdtc_pkg::t_cfg r_cfg;

    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width   <= sdtc_pkg::RST_FRAME_WIDTH;
            r_cfg.frame_height  <= sdtc_pkg::RST_FRAME_HEIGHT;
            r_cfg.double_mode   <= sdtc_pkg::RST_DOUBLE_MODE;
            r_cfg.single_thresh <= sdtc_pkg::RST_SINGLE_THRESH;
            r_cfg.low_thresh    <= sdtc_pkg::RST_LOW_THRESH;
            r_cfg.high_thresh   <= sdtc_pkg::RST_HIGH_THRESH;
        end else if (i_valid) begin
            unique case (sdtc_pkg::t_cfg_idx'(i_index))
                sdtc_pkg::CFG_FRAME_WIDTH: begin
                    r_cfg.frame_width <= i_data[sdtc_pkg::DIM_W-1:0];
                end
                sdtc_pkg::CFG_FRAME_HEIGHT: begin
                    r_cfg.frame_height <= i_data[sdtc_pkg::DIM_W-1:0];
                end
                sdtc_pkg::CFG_DOUBLE_MODE: begin
                    r_cfg.double_mode <= i_data[0];
                end
                sdtc_pkg::CFG_SINGLE_THRESH: begin
                    r_cfg.single_thresh <= i_data;
                end
                sdtc_pkg::CFG_LOW_THRESH: begin
                    r_cfg.low_thresh <= i_data;
                end
                sdtc_pkg::CFG_HIGH_THRESH: begin
                    r_cfg.high_thresh <= i_data;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/sdtc_line.sv =====
// ----------------------------------------------------------------------------
// Sobel classifier line buffer and gradient stage
// Tracks raster position, keeps the two previous rows in one memory and the
// two previous columns in a window, and forms gx and gy.
// ----------------------------------------------------------------------------
`default_nettype none

module sdtc_line #(
    parameter int MAX_WIDTH  = sdtc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sdtc_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_pix_valid,
    output logic                            o_pix_ready,
    input  wire logic [sdtc_pkg::PIX_W-1:0] i_intensity,
    input  wire logic [sdtc_pkg::DIM_W-1:0] i_frame_width,
    input  wire logic [sdtc_pkg::DIM_W-1:0] i_frame_height,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output sdtc_pkg::t_grad                 o_item
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int XW = (WW > sdtc_pkg::DIM_W) ? WW : sdtc_pkg::DIM_W;
    localparam int YW = (HW > sdtc_pkg::DIM_W) ? HW : sdtc_pkg::DIM_W;
    localparam int PW = sdtc_pkg::PIX_W;
    localparam int GW = sdtc_pkg::GRAD_W;
    localparam int QW = sdtc_pkg::POS_W;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [RW-1:0] n_row;
    logic [CW-1:0] n_col;

    logic          col_wrap;
    logic [HW-1:0] row_inc;
    logic [RW-1:0] row_now;
    logic [CW-1:0] col_now;
    logic [WW-1:0] col_plus;
    logic [HW-1:0] row_plus;
    logic          border;
    logic          accept;
    logic          fire_b;
    logic [CW-1:0] rd_addr;

    logic [sdtc_pkg::LINE_W-1:0] r_mem [MAX_WIDTH];
    logic [sdtc_pkg::LINE_W-1:0] r_q;

    logic          r_b_valid;
    logic [RW-1:0] r_b_row;
    logic [CW-1:0] r_b_col;
    logic [PW-1:0] r_b_x;
    logic          r_b_border;

    logic [PW-1:0] r_win [6];
    logic [PW-1:0] up_pix;
    logic [PW-1:0] mid_pix;
    logic          interior;

    logic signed [GW-1:0] a0, a1, a2, b0, b2, k0, k1, k2;
    logic signed [GW-1:0] gx, gy;

    logic            r_c_valid;
    sdtc_pkg::t_grad r_c_item;

    always_comb begin
        if (XW'(i_frame_width) > XW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else if (i_frame_width < sdtc_pkg::DIM_W'(sdtc_pkg::MIN_DIM)) begin
            w_eff = WW'(sdtc_pkg::MIN_DIM);
        end else begin
            w_eff = WW'(i_frame_width);
        end
        if (YW'(i_frame_height) > YW'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else if (i_frame_height < sdtc_pkg::DIM_W'(sdtc_pkg::MIN_DIM)) begin
            h_eff = HW'(sdtc_pkg::MIN_DIM);
        end else begin
            h_eff = HW'(i_frame_height);
        end
    end

    always_comb begin
        col_wrap = WW'(r_col) >= w_eff;
        col_now  = col_wrap ? '0 : r_col;
        row_inc  = col_wrap ? HW'(r_row) + HW'(1) : HW'(r_row);
        row_now  = (row_inc >= h_eff) ? '0 : RW'(row_inc);
        border   = (row_now == '0) || (HW'(row_now) == h_eff - HW'(1)) ||
                   (col_now == '0) || (WW'(col_now) == w_eff - WW'(1));
        col_plus = WW'(col_now) + WW'(1);
        row_plus = HW'(row_now) + HW'(1);
        if (col_plus >= w_eff) begin
            n_col = '0;
            n_row = (row_plus >= h_eff) ? '0 : RW'(row_plus);
        end else begin
            n_col = CW'(col_plus);
            n_row = row_now;
        end
    end

    assign fire_b      = r_b_valid && (!r_c_valid || i_ready);
    assign accept      = i_pix_valid && (!r_b_valid || fire_b);
    assign o_pix_ready = !r_b_valid || fire_b;
    assign rd_addr     = accept ? col_now : r_b_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_b) begin
            r_mem[r_b_col] <= {mid_pix, r_b_x};
        end
        r_q <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (accept) begin
            r_b_valid <= 1'b1;
        end else if (fire_b) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_row    <= row_now;
            r_b_col    <= col_now;
            r_b_x      <= border ? '0 : i_intensity;
            r_b_border <= border;
        end
    end

    assign up_pix   = r_q[sdtc_pkg::LINE_W-1:PW];
    assign mid_pix  = r_q[PW-1:0];
    assign interior = (r_b_row >= RW'(2)) && (r_b_col >= CW'(2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (fire_b) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i] <= (r_b_col == '0) ? '0 : r_win[i+3];
            end
            r_win[3] <= up_pix;
            r_win[4] <= mid_pix;
            r_win[5] <= r_b_x;
        end
    end

    always_comb begin
        a0 = $signed(GW'(r_win[0]));
        a1 = $signed(GW'(r_win[1]));
        a2 = $signed(GW'(r_win[2]));
        b0 = $signed(GW'(r_win[3]));
        b2 = $signed(GW'(r_win[5]));
        k0 = $signed(GW'(up_pix));
        k1 = $signed(GW'(mid_pix));
        k2 = $signed(GW'(r_b_x));
        gy = a0 + (b0 <<< 1) + k0 - a2 - (b2 <<< 1) - k2;
        gx = a0 - k0 + (a1 <<< 1) - (k1 <<< 1) + a2 - k2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (fire_b) begin
            r_c_valid <= 1'b1;
        end else if (i_ready) begin
            r_c_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_b) begin
            r_c_item.has_int <= interior;
            r_c_item.has_bdr <= r_b_border;
            r_c_item.int_row <= QW'(r_b_row - RW'(1));
            r_c_item.int_col <= QW'(r_b_col - CW'(1));
            r_c_item.bdr_row <= QW'(r_b_row);
            r_c_item.bdr_col <= QW'(r_b_col);
            r_c_item.gx      <= gx;
            r_c_item.gy      <= gy;
        end
    end

    assign o_valid = r_c_valid;
    assign o_item  = r_c_item;

endmodule

`default_nettype wire

// ===== sv/sdtc_grad.sv =====
// ----------------------------------------------------------------------------
// Sobel classifier magnitude and threshold stages
// Squares gx and gy, sums them and classifies against the thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module sdtc_grad (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  sdtc_pkg::t_grad                 i_item,
    input  wire logic                       i_double_mode,
    input  wire logic [sdtc_pkg::THR_W-1:0] i_single_thresh,
    input  wire logic [sdtc_pkg::THR_W-1:0] i_low_thresh,
    input  wire logic [sdtc_pkg::THR_W-1:0] i_high_thresh,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output sdtc_pkg::t_cls                  o_item
);

    localparam int PRW = 2 * sdtc_pkg::GRAD_W;

    logic signed [PRW-1:0] gx_sq;
    logic signed [PRW-1:0] gy_sq;

    logic                          r_s_valid;
    sdtc_pkg::t_grad               r_s_item;
    logic [sdtc_pkg::SQ_W-1:0]     r_s_gx2;
    logic [sdtc_pkg::SQ_W-1:0]     r_s_gy2;

    logic [sdtc_pkg::MAG_W-1:0]    mag;
    sdtc_pkg::t_cls_code           cls;
    logic                          fire_s;

    logic                          r_k_valid;
    sdtc_pkg::t_cls                r_k_item;

    assign gx_sq = i_item.gx * i_item.gx;
    assign gy_sq = i_item.gy * i_item.gy;

    assign fire_s  = r_s_valid && (!r_k_valid || i_ready);
    assign o_ready = !r_s_valid || fire_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_s_valid <= 1'b1;
        end else if (fire_s) begin
            r_s_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s_item <= i_item;
            r_s_gx2  <= gx_sq[sdtc_pkg::SQ_W-1:0];
            r_s_gy2  <= gy_sq[sdtc_pkg::SQ_W-1:0];
        end
    end

    assign mag = sdtc_pkg::MAG_W'(r_s_gx2) + sdtc_pkg::MAG_W'(r_s_gy2);

    always_comb begin
        priority if (!i_double_mode) begin
            cls = (mag >= i_single_thresh) ? sdtc_pkg::CLS_WEAK : sdtc_pkg::CLS_NONE;
        end else if (mag <= i_low_thresh) begin
            cls = sdtc_pkg::CLS_NONE;
        end else if (mag <= i_high_thresh) begin
            cls = sdtc_pkg::CLS_WEAK;
        end else begin
            cls = sdtc_pkg::CLS_STRONG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_valid <= 1'b0;
        end else if (fire_s) begin
            r_k_valid <= 1'b1;
        end else if (i_ready) begin
            r_k_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_s) begin
            r_k_item.has_int <= r_s_item.has_int;
            r_k_item.has_bdr <= r_s_item.has_bdr;
            r_k_item.int_row <= r_s_item.int_row;
            r_k_item.int_col <= r_s_item.int_col;
            r_k_item.int_cls <= cls;
            r_k_item.bdr_row <= r_s_item.bdr_row;
            r_k_item.bdr_col <= r_s_item.bdr_col;
        end
    end

    assign o_valid = r_k_valid;
    assign o_item  = r_k_item;

endmodule

`default_nettype wire

// ===== sv/sdtc_obuf.sv =====
// ----------------------------------------------------------------------------
// Sobel classifier output buffer
// Holds one pixel's results and sends the delayed interior result first,
// then the border result, marking the final one.
// ----------------------------------------------------------------------------
`default_nettype none

module sdtc_obuf (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  sdtc_pkg::t_cls                   i_item,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [sdtc_pkg::POS_W-1:0]       o_pixel_row,
    output logic [sdtc_pkg::POS_W-1:0]       o_pixel_col,
    output logic [sdtc_pkg::CLS_W-1:0]       o_edge_class,
    output logic                             o_last
);

    sdtc_pkg::t_cls r_item;
    logic           r_pend_int;
    logic           r_pend_bdr;
    logic           send;

    assign o_valid = r_pend_int || r_pend_bdr;
    assign o_last  = !(r_pend_int && r_pend_bdr);
    assign send    = o_valid && i_ready;
    assign o_ready = !o_valid || (send && o_last);

    always_comb begin
        if (r_pend_int) begin
            o_pixel_row  = r_item.int_row;
            o_pixel_col  = r_item.int_col;
            o_edge_class = r_item.int_cls;
        end else begin
            o_pixel_row  = r_item.bdr_row;
            o_pixel_col  = r_item.bdr_col;
            o_edge_class = sdtc_pkg::CLS_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_int <= 1'b0;
            r_pend_bdr <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_pend_int <= i_item.has_int;
            r_pend_bdr <= i_item.has_bdr;
        end else if (send) begin
            if (r_pend_int) begin
                r_pend_int <= 1'b0;
            end else begin
                r_pend_bdr <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sobel_double_threshold_classifier_unit.sv =====
// Latency: a pixel's first result reaches the output through the line stage,
// gradient register, square stage, class stage and output buffer registers.
// Throughput: one pixel per cycle unless the output stalls; a pixel giving
// two results (right border column and bottom row) holds the output buffer
// until both are sent. The line memory is read at accept and written back
// as the pixel advances. Reset: synchronous, active low; position counters,
// valids and the window are cleared and registers take their defaults.
// Sobel double-threshold classifier unit
// Streams grey pixels in raster order and classifies Sobel edge magnitude.
// Register defaults restored at reset, line memory undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_double_threshold_classifier_unit #(
    parameter int MAX_WIDTH  = sdtc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sdtc_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sdtc_pix_if.sink    i_pix,
    sdtc_res_if.source  o_res,
    sdtc_cfg_if.sink    i_cfg
);

    sdtc_pkg::t_cfg  cfg;
    logic            grad_valid;
    logic            grad_ready;
    sdtc_pkg::t_grad grad_item;
    logic            cls_valid;
    logic            cls_ready;
    sdtc_pkg::t_cls  cls_item;

    sdtc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg.valid),
        .o_ready (i_cfg.ready),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    sdtc_line #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_line (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pix_valid    (i_pix.valid),
        .o_pix_ready    (i_pix.ready),
        .i_intensity    (i_pix.intensity),
        .i_frame_width  (cfg.frame_width),
        .i_frame_height (cfg.frame_height),
        .o_valid        (grad_valid),
        .i_ready        (grad_ready),
        .o_item         (grad_item)
    );

    sdtc_grad u_grad (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (grad_valid),
        .o_ready         (grad_ready),
        .i_item          (grad_item),
        .i_double_mode   (cfg.double_mode),
        .i_single_thresh (cfg.single_thresh),
        .i_low_thresh    (cfg.low_thresh),
        .i_high_thresh   (cfg.high_thresh),
        .o_valid         (cls_valid),
        .i_ready         (cls_ready),
        .o_item          (cls_item)
    );

    sdtc_obuf u_obuf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (cls_valid),
        .o_ready      (cls_ready),
        .i_item       (cls_item),
        .o_valid      (o_res.valid),
        .i_ready      (o_res.ready),
        .o_pixel_row  (o_res.pixel_row),
        .o_pixel_col  (o_res.pixel_col),
        .o_edge_class (o_res.edge_class),
        .o_last       (o_res.last)
    );

endmodule

`default_nettype wire

// ===== tb/sv/sobel_double_threshold_classifier_unit_test.sv =====
// ----------------------------------------------------------------------------
// Sobel double-threshold classifier unit testbench
// Streams pixel frames of many sizes and threshold settings through the unit,
// predicts every classified pixel in a shadow copy of the window and line
// state, and checks each result by position, class and last flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_double_threshold_classifier_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sdtc_pkg::*;

    localparam int                QUIET_LIMIT   = 2000;
    localparam int                END_LIMIT     = 1000;
    localparam int                SETTLE_CYCLES = 12;
    localparam int                HOLD_CYCLES   = 200;
    localparam int                IDLE_PCT      = 36;
    localparam int                LARGE_RUN     = 60;
    localparam logic [THR_W-1:0]  THR_MAX       = '1;
    localparam logic [IDX_W-1:0]  CFG_UNMAPPED_A = 3'd6;
    localparam logic [IDX_W-1:0]  CFG_UNMAPPED_B = 3'd7;

    typedef struct {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        t_cls_code        cls;
        logic             last;
    } edge_result_t;

    logic i_clk;
    logic i_rst_n;

    sdtc_pix_if pix_if ();
    sdtc_res_if res_if ();
    sdtc_cfg_if cfg_if ();

    sobel_double_threshold_classifier_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // shadow state of the classifier
    t_cfg             shadow_cfg;
    logic [PIX_W-1:0] prev2_line [MAX_WIDTH_DEF];
    logic [PIX_W-1:0] prev1_line [MAX_WIDTH_DEF];
    int               taps [6];
    int unsigned      next_row;
    int unsigned      next_col;
    edge_result_t     expected_edges [$];

    int  pixels_taken;
    int  results_checked;
    int  regs_written;
    int  settings_used;
    int  mismatches;
    int  quiet;
    bit  idle_on;
    int  hold_req;
    int  hold_ack;
    int  hold_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void predict_edges(input logic [PIX_W-1:0] raw);
        int unsigned  w, h, r, c;
        int           x, u, m, gx, gy, mag;
        bit           border;
        edge_result_t res;
        w = eff_dim(shadow_cfg.frame_width, MAX_WIDTH_DEF);
        h = eff_dim(shadow_cfg.frame_height, MAX_HEIGHT_DEF);
        if (next_col >= w) begin
            next_col = 0;
            next_row++;
        end
        if (next_row >= h) next_row = 0;
        r = next_row;
        c = next_col;
        border = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);
        x = border ? 0 : int'(raw);
        u = prev2_line[c];
        m = prev1_line[c];
        prev2_line[c] = m[PIX_W-1:0];
        prev1_line[c] = x[PIX_W-1:0];
        if (r >= 2 && c >= 2) begin
            gy = taps[0] + 2 * taps[3] + u - taps[2] - 2 * taps[5] - x;
            gx = taps[0] - u + 2 * taps[1] - 2 * m + taps[2] - x;
            mag = gx * gx + gy * gy;
            res.row  = POS_W'(r - 1);
            res.col  = POS_W'(c - 1);
            res.last = !border;
            if (!shadow_cfg.double_mode) begin
                if (mag >= int'(shadow_cfg.single_thresh)) res.cls = CLS_WEAK;
                else res.cls = CLS_NONE;
            end else if (mag <= int'(shadow_cfg.low_thresh)) begin
                res.cls = CLS_NONE;
            end else if (mag <= int'(shadow_cfg.high_thresh)) begin
                res.cls = CLS_WEAK;
            end else begin
                res.cls = CLS_STRONG;
            end
            expected_edges.insert(expected_edges.size(), res);
        end
        if (border) begin
            res.row  = POS_W'(r);
            res.col  = POS_W'(c);
            res.cls  = CLS_NONE;
            res.last = 1'b1;
            expected_edges.insert(expected_edges.size(), res);
        end
        if (c == 0) taps = '{default: 0};
        taps[0] = taps[3];
        taps[1] = taps[4];
        taps[2] = taps[5];
        taps[3] = u;
        taps[4] = m;
        taps[5] = x;
        next_col = c + 1;
        if (next_col >= w) begin
            next_col = 0;
            next_row = r + 1;
            if (next_row >= h) next_row = 0;
        end
    endfunction

    always @(posedge i_clk) begin : track
        edge_result_t due;
        bit           moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (res_if.valid && res_if.ready) begin
                moved = 1'b1;
                results_checked++;
                if (expected_edges.size() == 0) begin
                    $error("unexpected result row %0d col %0d class %0d",
                           res_if.pixel_row, res_if.pixel_col, res_if.edge_class);
                    mismatches++;
                end else begin
                    due = expected_edges.pop_front();
                    if (res_if.pixel_row !== due.row) begin
                        $error("pixel_row expected %0d got %0d", due.row, res_if.pixel_row);
                        mismatches++;
                    end
                    if (res_if.pixel_col !== due.col) begin
                        $error("pixel_col expected %0d got %0d", due.col, res_if.pixel_col);
                        mismatches++;
                    end
                    if (res_if.edge_class !== due.cls) begin
                        $error("edge_class expected %0d got %0d at row %0d col %0d",
                               due.cls, res_if.edge_class, due.row, due.col);
                        mismatches++;
                    end
                    if (res_if.last !== due.last) begin
                        $error("last expected %0d got %0d at row %0d col %0d",
                               due.last, res_if.last, due.row, due.col);
                        mismatches++;
                    end
                end
            end
            if (pix_if.valid && pix_if.ready) begin
                moved = 1'b1;
                pixels_taken++;
                predict_edges(pix_if.intensity);
            end
            if (cfg_if.valid && cfg_if.ready) begin
                moved = 1'b1;
                regs_written++;
                case (cfg_if.index)
                    CFG_FRAME_WIDTH:   shadow_cfg.frame_width   = cfg_if.data[DIM_W-1:0];
                    CFG_FRAME_HEIGHT:  shadow_cfg.frame_height  = cfg_if.data[DIM_W-1:0];
                    CFG_DOUBLE_MODE:   shadow_cfg.double_mode   = cfg_if.data[0];
                    CFG_SINGLE_THRESH: shadow_cfg.single_thresh = cfg_if.data;
                    CFG_LOW_THRESH:    shadow_cfg.low_thresh    = cfg_if.data;
                    CFG_HIGH_THRESH:   shadow_cfg.high_thresh   = cfg_if.data;
                    default: ;
                endcase
            end
            quiet = moved ? 0 : quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("[sobel_double_threshold_classifier_unit] ERROR");
                $finish;
            end
        end
    end

    // result sink: random stalls plus a counted hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] value);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid     <= 1'b1;
        pix_if.intensity <= value;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_edges.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] index, input logic [THR_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= index;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // a wider frame only starts on a frame boundary, so finish the frame first
    task automatic configure(input logic [THR_W-1:0] width, height, mode,
                             single_t, low_t, high_t, input bit align);
        int unsigned w, h, r, c, fill;
        wait_idle();
        w = eff_dim(shadow_cfg.frame_width, MAX_WIDTH_DEF);
        h = eff_dim(shadow_cfg.frame_height, MAX_HEIGHT_DEF);
        r = next_row;
        c = next_col;
        if (c >= w) begin
            c = 0;
            r++;
        end
        if (r >= h) r = 0;
        fill = (r == 0 && c == 0) ? 0 : (h - r) * w - c;
        if (fill != 0 && (align || eff_dim(width[DIM_W-1:0], MAX_WIDTH_DEF) > w)) begin
            repeat (fill) send_pixel(PIX_W'($urandom_range(255)));
            wait_idle();
        end
        settings_used++;
        write_reg(CFG_FRAME_WIDTH, width);
        write_reg(CFG_FRAME_HEIGHT, height);
        write_reg(CFG_DOUBLE_MODE, mode);
        write_reg(CFG_SINGLE_THRESH, single_t);
        write_reg(CFG_LOW_THRESH, low_t);
        write_reg(CFG_HIGH_THRESH, high_t);
    endtask

    function automatic logic [THR_W-1:0] pick_threshold();
        case ($urandom_range(3))
            0:       return THR_W'($urandom_range(THR_MAX));
            1:       return THR_W'($urandom_range(60000));
            2:       return THR_W'($urandom_range(300000));
            default: return $urandom_range(1) ? THR_MAX : '0;
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h5A);
    endtask

    // masked upper data bits, clamped sizes, unmapped indexes, threshold zero
    task automatic test_register_map();
        int i;
        configure(21'h1FF804, 21'd1, 21'h1FFFFE, 21'd0, THR_MAX, 21'd0, 1'b0);
        write_reg(CFG_UNMAPPED_A, THR_MAX);
        write_reg(CFG_UNMAPPED_B, 21'd0);
        for (i = 0; i < 9; i++) send_pixel(i[0] ? 8'h00 : 8'hFF);
    endtask

    // border pixels forced dark; magnitude zero at low, 260100 above high
    task automatic test_class_boundaries();
        int i;
        configure(21'd4, 21'd3, 21'd1, THR_MAX, 21'd0, 21'd260099, 1'b1);
        for (i = 0; i < 12; i++) send_pixel(i == 6 ? 8'h00 : 8'hFF);
    endtask

    task automatic test_random_frames();
        int               phase, i, style, level, count;
        logic [THR_W-1:0] w, h;
        logic [PIX_W-1:0] value;
        for (phase = 0; phase < 8; phase++) begin
            w = ($urandom_range(7) == 0) ? THR_W'($urandom_range(2)) : THR_W'($urandom_range(3, 12));
            h = ($urandom_range(7) == 0) ? THR_W'($urandom_range(2)) : THR_W'($urandom_range(3, 8));
            configure(w, h, THR_W'($urandom_range(1)), pick_threshold(), pick_threshold(),
                      pick_threshold(), bit'($urandom_range(1)));
            idle_on = (phase != 3);
            style = $urandom_range(2);
            level = $urandom_range(255);
            count = $urandom_range(30, 50);
            for (i = 0; i < count; i++) begin
                case (style)
                    0: value = PIX_W'($urandom_range(255));
                    1: value = $urandom_range(1) ? 8'hFF : 8'h00;
                    default: begin
                        level = level + int'($urandom_range(8)) - 4;
                        if (level < 0) level = 0;
                        if (level > 255) level = 255;
                        value = PIX_W'(level);
                    end
                endcase
                send_pixel(value);
            end
            idle_on = 1'b1;
        end
    endtask

    task automatic test_output_backpressure();
        configure(21'd8, 21'd6, THR_W'($urandom_range(1)), pick_threshold(),
                  pick_threshold(), pick_threshold(), 1'b0);
        idle_on = 1'b0;
        hold_req <= hold_req + 1;
        repeat (80) send_pixel(PIX_W'($urandom_range(255)));
        idle_on = 1'b1;
    endtask

    // oversized width, then the largest height with the position kept mid-frame
    task automatic test_largest_frames();
        idle_on = 1'b0;
        configure(21'd2047, 21'd0, 21'd1, pick_threshold(), pick_threshold(),
                  pick_threshold(), 1'b1);
        repeat (LARGE_RUN) send_pixel(PIX_W'($urandom_range(255)));
        configure(21'd3, 21'd1024, 21'd0, pick_threshold(), pick_threshold(),
                  pick_threshold(), 1'b0);
        repeat (LARGE_RUN) send_pixel(PIX_W'($urandom_range(255)));
        idle_on = 1'b1;
    endtask

    initial begin : run
        int waited;
        i_rst_n          = 1'b0;
        pix_if.valid     = 1'b0;
        pix_if.intensity = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.data      = '0;
        res_if.ready     = 1'b0;
        idle_on          = 1'b1;
        hold_req         = 0;
        hold_ack         = 0;
        hold_left        = 0;
        quiet            = 0;
        pixels_taken     = 0;
        results_checked  = 0;
        regs_written     = 0;
        settings_used    = 0;
        mismatches       = 0;
        next_row         = 0;
        next_col         = 0;
        taps             = '{default: 0};
        foreach (prev2_line[i]) prev2_line[i] = '0;
        foreach (prev1_line[i]) prev1_line[i] = '0;
        shadow_cfg.frame_width   = RST_FRAME_WIDTH;
        shadow_cfg.frame_height  = RST_FRAME_HEIGHT;
        shadow_cfg.double_mode   = RST_DOUBLE_MODE;
        shadow_cfg.single_thresh = RST_SINGLE_THRESH;
        shadow_cfg.low_thresh    = RST_LOW_THRESH;
        shadow_cfg.high_thresh   = RST_HIGH_THRESH;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_register_map();
        test_class_boundaries();
        test_random_frames();
        test_output_backpressure();
        test_largest_frames();

        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        for (waited = 0; expected_edges.size() != 0 && waited < END_LIMIT; waited++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_edges.size() != 0) begin
            $error("%0d expected results never arrived", expected_edges.size());
            mismatches++;
        end

        $display("Streamed %0d pixels over %0d frame settings (%0d register writes),",
                 pixels_taken, settings_used, regs_written);
        $display("checked %0d classified results, %0d mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0) begin
            $display("[sobel_double_threshold_classifier_unit] OK");
        end else begin
            $display("[sobel_double_threshold_classifier_unit] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/sdtc_pkg.sv
sv/sdtc_if.sv
sv/sdtc_cfg.sv
sv/sdtc_line.sv
sv/sdtc_grad.sv
sv/sdtc_obuf.sv
sv/sobel_double_threshold_classifier_unit.sv
tb/sv/sobel_double_threshold_classifier_unit_test.sv
